// ===== src/rdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter package
// Widths, stack sizing and the control bundle shared by the converter modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int unsigned VALUE_W     = 31;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned S_TDATA_W   = ((VALUE_W + RADIX_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W   = ((DIGIT_W + 7) / 8) * 8;

    localparam int unsigned RADIX_MIN   = 2;
    localparam int unsigned RADIX_MAX   = 16;

    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int unsigned STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    localparam int unsigned DIV_BITS_PER_CYCLE = 8;
    localparam int unsigned DIV_CYCLES  = (VALUE_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int unsigned DIV_W       = DIV_CYCLES * DIV_BITS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [DIGIT_W-1:0] data;
    } t_stack_ctrl;

endpackage

// ===== src/rdc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter divider
// Iterative restoring divider that retires eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module rdc_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rdc_pkg::VALUE_W-1:0]  i_dividend,
    input  logic [rdc_pkg::RADIX_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [rdc_pkg::VALUE_W-1:0]  o_quotient,
    output logic [rdc_pkg::DIGIT_W-1:0]  o_remainder
);

    logic                           r_busy;
    logic                           n_busy;
    logic                           r_done;
    logic                           n_done;
    logic [rdc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [rdc_pkg::DIV_CNT_W-1:0]  n_cnt;
    logic [rdc_pkg::DIV_W-1:0]      r_q;
    logic [rdc_pkg::DIV_W-1:0]      n_q;
    logic [rdc_pkg::DIGIT_W-1:0]    r_rem;
    logic [rdc_pkg::DIGIT_W-1:0]    n_rem;
    logic [rdc_pkg::DIV_W-1:0]      w_q;
    logic [rdc_pkg::DIGIT_W-1:0]    w_rem;

    always_comb begin
        logic [rdc_pkg::RADIX_W-1:0] t;
        logic                        b;
        w_q   = r_q;
        w_rem = r_rem;
        for (int i = 0; i < int'(rdc_pkg::DIV_BITS_PER_CYCLE); i++) begin
            t = {w_rem, w_q[rdc_pkg::DIV_W-1]};
            b = (t >= i_divisor);
            if (b) begin
                t = t - i_divisor;
            end
            w_rem = t[rdc_pkg::DIGIT_W-1:0];
            w_q   = {w_q[rdc_pkg::DIV_W-2:0], b};
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = rdc_pkg::DIV_CNT_W'(rdc_pkg::DIV_CYCLES);
            n_q    = rdc_pkg::DIV_W'(i_dividend);
            n_rem  = '0;
        end else if (r_busy) begin
            n_q   = w_q;
            n_rem = w_rem;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == rdc_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q[rdc_pkg::VALUE_W-1:0];
    assign o_remainder = r_rem;

endmodule

// ===== src/rdc_digit_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter stack
// Last-in first-out store of digits with a fill count.
// ----------------------------------------------------------------------------
module rdc_digit_stack (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rdc_pkg::t_stack_ctrl             i_ctrl,
    output logic [rdc_pkg::STACK_CNT_W-1:0]  o_count,
    output logic [rdc_pkg::DIGIT_W-1:0]      o_top
);

    logic [rdc_pkg::DIGIT_W-1:0]     r_mem [rdc_pkg::STACK_DEPTH];
    logic [rdc_pkg::STACK_CNT_W-1:0] r_count;
    logic [rdc_pkg::STACK_CNT_W-1:0] n_count;
    logic [rdc_pkg::STACK_CNT_W-1:0] w_top_cnt;
    logic                            w_full;
    logic                            w_empty;

    assign w_full    = (r_count == rdc_pkg::STACK_CNT_W'(rdc_pkg::STACK_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_top_cnt = r_count - 1'b1;

    always_comb begin
        n_count = r_count;
        if (i_ctrl.push && !w_full) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop && !w_empty) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        if (i_ctrl.push && !w_full) begin
            r_mem[r_count[rdc_pkg::STACK_IDX_W-1:0]] <= i_ctrl.data;
        end
    end

    assign o_count = r_count;
    assign o_top   = r_mem[w_top_cnt[rdc_pkg::STACK_IDX_W-1:0]];

endmodule

// ===== src/radix_digit_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts a non-negative integer into its digits in a radix from 2 to 16.
// ----------------------------------------------------------------------------
// The slave stream carries one conversion per transfer: the value in tdata
// bits 30:0 and the radix in bits 35:31. A radix below 2 is treated as 2 and
// one above 16 as 16. The master stream returns one transfer per digit, most
// significant first, with the digit in tdata bits 3:0 and tlast on the final,
// least significant digit. A value of zero gives one digit 0 with tlast.
// Digits come from repeated division by the radix in one shared divider that
// retires eight quotient bits per cycle; each division is preceded by a
// compare against the radix. A value with D digits is divided D-1 times and
// its D digits are then emitted before the return to idle, at most 31 digits
// for radix 2. The slave side is not ready while a conversion is in
// progress; it becomes ready again once the stack has emptied and the state
// machine has returned to idle, even if the receiver has not taken the last
// digit yet. When the receiver stalls, digits wait in the output register and
// popping stops. Reset empties the digit stack, clears the master stream's
// valid state and returns the converter to idle, so the slave side is ready.
// ----------------------------------------------------------------------------
module radix_digit_converter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: value (31), radix (5), zero fill (4).
    input  logic [rdc_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: digit (4), zero fill (4).
    output logic [rdc_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                             o_m_axis_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [rdc_pkg::VALUE_W-1:0]       r_val;
    logic [rdc_pkg::VALUE_W-1:0]       n_val;
    logic [rdc_pkg::RADIX_W-1:0]       r_radix;
    logic [rdc_pkg::RADIX_W-1:0]       n_radix;
    logic                              r_ovalid;
    logic                              n_ovalid;
    logic [rdc_pkg::DIGIT_W-1:0]       r_odigit;
    logic [rdc_pkg::DIGIT_W-1:0]       n_odigit;
    logic                              r_olast;
    logic                              n_olast;

    rdc_pkg::t_stack_ctrl              w_sctrl;
    logic [rdc_pkg::STACK_CNT_W-1:0]   w_count;
    logic [rdc_pkg::DIGIT_W-1:0]       w_top;
    logic                              w_div_start;
    logic                              w_div_done;
    logic [rdc_pkg::VALUE_W-1:0]       w_quo;
    logic [rdc_pkg::DIGIT_W-1:0]       w_rem;
    logic                              w_in_fire;
    logic                              w_load;
    logic [rdc_pkg::VALUE_W-1:0]       w_in_value;
    logic [rdc_pkg::RADIX_W-1:0]       w_in_radix;
    logic [rdc_pkg::RADIX_W-1:0]       w_sat_radix;

    assign w_in_value = i_s_axis_tdata[rdc_pkg::VALUE_W-1:0];
    assign w_in_radix = i_s_axis_tdata[rdc_pkg::VALUE_W +: rdc_pkg::RADIX_W];

    always_comb begin
        if (w_in_radix < rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MIN)) begin
            w_sat_radix = rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MIN);
        end else if (w_in_radix > rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MAX)) begin
            w_sat_radix = rdc_pkg::RADIX_W'(rdc_pkg::RADIX_MAX);
        end else begin
            w_sat_radix = w_in_radix;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = (r_state == ST_EMIT) && (w_count != '0)
                             && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        n_state      = r_state;
        n_val        = r_val;
        n_radix      = r_radix;
        w_div_start  = 1'b0;
        w_sctrl.push = 1'b0;
        w_sctrl.pop  = 1'b0;
        w_sctrl.data = r_val[rdc_pkg::DIGIT_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_val   = w_in_value;
                    n_radix = w_sat_radix;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_val >= rdc_pkg::VALUE_W'(r_radix)) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    w_sctrl.push = 1'b1;
                    n_state      = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_sctrl.push = 1'b1;
                    w_sctrl.data = w_rem;
                    n_val        = w_quo;
                    n_state      = ST_CHECK;
                end
            end
            ST_EMIT: begin
                w_sctrl.pop = w_load;
                if (w_count == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        n_odigit = r_odigit;
        n_olast  = r_olast;
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        if (w_load) begin
            n_ovalid = 1'b1;
            n_odigit = w_top;
            n_olast  = (w_count == rdc_pkg::STACK_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_val    <= n_val;
        r_radix  <= n_radix;
        r_odigit <= n_odigit;
        r_olast  <= n_olast;
    end

    rdc_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_val),
        .i_divisor   (r_radix),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    rdc_digit_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_sctrl),
        .o_count (w_count),
        .o_top   (w_top)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = rdc_pkg::M_TDATA_W'(r_odigit);
    assign o_m_axis_tlast  = r_olast;

    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (w_count == '0))
        else $error("Converter is ready while digits remain on the stack.");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("Divider finished outside the division state.");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_count == rdc_pkg::STACK_CNT_W'(1))) |=> (w_count == '0))
        else $error("Stack not empty after the final digit was loaded.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= rdc_pkg::STACK_CNT_W'(rdc_pkg::STACK_DEPTH))
        else $error("Digit count exceeds the stack depth.");

endmodule
